/* src/gha_pkg.sv */
// ============================================================================
// gha_pkg - shared types and constants of the generational handle allocator
// Slot table geometry, command and status codes, stream word layout.
// ============================================================================
`default_nettype none

package gha_pkg;

  // Slot table geometry
  localparam int SLOTS      = 64;
  localparam int GEN_BITS   = 16;
  localparam int SLOT_IDX_W = $clog2(SLOTS);

  // Free-slot search: groups of GRP_SIZE slots, group first, then slot in group
  localparam int GRP_SIZE   = 8;
  localparam int GRP_CNT    = SLOTS / GRP_SIZE;
  localparam int GRP_IDX_W  = $clog2(GRP_CNT);
  localparam int SEL_W      = $clog2(GRP_SIZE);

  // Stream field widths (fixed by the request and result formats)
  localparam int CMD_W      = 3;
  localparam int SLOT_W     = 6;
  localparam int GEN_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int TDATA_W    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 3'd0,
    CMD_FORCE    = 3'd1,
    CMD_EXISTS   = 3'd2,
    CMD_ALIVE    = 3'd3,
    CMD_REQ_DEL  = 3'd4,
    CMD_DELETE   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_OCCUPIED  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Generation memory port bundle
  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_addr;
    logic [GEN_BITS-1:0]   wr_data;
  } gen_mem_req_t;

endpackage

`default_nettype wire

/* src/gha_ram.sv */
// ============================================================================
// gha_ram - single-port-write, single-port-read RAM with registered read
// Holds one generation counter per slot.
// ============================================================================
`default_nettype none

module gha_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/gha_finder.sv */
// ============================================================================
// gha_finder - lowest free slot search over the occupancy bitmap
// The first step registers the lowest group with a free slot, the second
// picks the lowest free slot within that registered group.
// ============================================================================
`default_nettype none

module gha_finder (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [gha_pkg::SLOTS-1:0]     free_vec,
  output      logic [gha_pkg::SLOT_IDX_W-1:0] slot,
  output      logic                          found
);

  import gha_pkg::*;

  logic [GRP_CNT-1:0]   grp_any;
  logic [GRP_IDX_W-1:0] grp_sel;
  logic [GRP_IDX_W-1:0] grp_r;
  logic                 grp_found_r;
  logic [GRP_SIZE-1:0]  grp_bits;
  logic [SEL_W-1:0]     bit_sel;

  always_comb begin
    for (int g = 0; g < GRP_CNT; g++) begin
      grp_any[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
    end
    grp_sel = '0;
    for (int g = GRP_CNT - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GRP_IDX_W'(g);
      end
    end
  end

  always_comb begin
    grp_bits = free_vec[grp_r*GRP_SIZE +: GRP_SIZE];
    bit_sel  = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = SEL_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r       <= grp_sel;
      grp_found_r <= |grp_any;
    end
  end

  assign slot  = {grp_r, bit_sel};
  assign found = grp_found_r;

endmodule

`default_nettype wire

/* src/generational_handle_allocator_top.sv */
// ============================================================================
// generational_handle_allocator_top - generational slot handle allocator
// Sequencer over the occupancy and pending-delete bitmaps, a generation RAM
// and one shared compare/increment unit. One result per request.
// ============================================================================
// Sequencing: a request is taken in S_IDLE and answered from S_EXEC; allocate
//   first passes S_FIND and S_PICK (two-step free search, registered RAM read).
// Throughput: a new request is taken only once the previous one is answered;
//   a waiting result stalls the next request only in its final state, S_EXEC.
// Reset: rst_n (synchronous, active low) frees every slot and zeroes every
//   generation at once through per-slot valid bits; no clearing pass.
`default_nettype none

module generational_handle_allocator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  // [2:0] command, [8:3] slot, [24:9] generation, [31:25] zero
  input  wire logic [gha_pkg::TDATA_W-1:0] in_tdata,
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  // [1:0] status, [2] answer, [8:3] out_slot, [24:9] out_generation, [31:25] zero
  output      logic [gha_pkg::TDATA_W-1:0] out_tdata
);

  import gha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_PICK,
    S_EXEC
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [GEN_BITS-1:0]   gen_r, gen_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic                  full_r, full_nxt;
  logic [SLOTS-1:0]      occ_r, occ_nxt;
  logic [SLOTS-1:0]      pend_r, pend_nxt;
  logic [SLOTS-1:0]      gvld_r, gvld_nxt;
  logic                  gvld_q_r, gvld_q_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TDATA_W-1:0]    out_data_r, out_data_nxt;

  logic [CMD_W-1:0]      in_cmd;
  logic [SLOT_W-1:0]     in_slot;
  logic [GEN_W-1:0]      in_gen;
  logic [SLOTS-1:0]      free_vec;
  logic                  fnd_load;
  logic [SLOT_IDX_W-1:0] fnd_slot;
  logic                  fnd_found;
  gen_mem_req_t          mem_req;
  logic [GEN_BITS-1:0]   ram_q;

  // Shared compare / increment unit
  logic [GEN_BITS-1:0]   cur_gen;
  logic [GEN_BITS-1:0]   gen_inc;
  logic                  match;
  logic                  in_range;

  assign in_cmd  = in_tdata[CMD_W-1:0];
  assign in_slot = in_tdata[CMD_W +: SLOT_W];
  assign in_gen  = in_tdata[CMD_W+SLOT_W +: GEN_W];

  // Slot 0 is never handed out by allocate
  assign free_vec = ~occ_r & ~SLOTS'(1);
  assign fnd_load = (state_r == S_FIND);

  gha_finder u_finder (
    .clk      (clk),
    .load     (fnd_load),
    .free_vec (free_vec),
    .slot     (fnd_slot),
    .found    (fnd_found)
  );

  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH (GEN_BITS)
  ) u_gen_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (ram_q)
  );

  assign cur_gen  = gvld_q_r ? ram_q : '0;
  assign gen_inc  = cur_gen + GEN_BITS'(1);
  assign match    = occ_r[idx_r] && (cur_gen == gen_r);
  assign in_range = (int'(slot_r) < SLOTS);

  always_comb begin
    status_t             st;
    logic                ans;
    logic [SLOT_W-1:0]   oslot;
    logic [GEN_BITS-1:0] ogen;

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    gen_nxt       = gen_r;
    idx_nxt       = idx_r;
    full_nxt      = full_r;
    occ_nxt       = occ_r;
    pend_nxt      = pend_r;
    gvld_nxt      = gvld_r;
    gvld_q_nxt    = gvld_q_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    st    = ST_NOT_FOUND;
    ans   = 1'b0;
    oslot = slot_r;
    ogen  = '0;

    mem_req         = '0;
    mem_req.wr_addr = idx_r;
    mem_req.rd_addr = (state_r == S_PICK) ? fnd_slot : SLOT_IDX_W'(in_slot);

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = cmd_t'(in_cmd);
          slot_nxt      = in_slot;
          gen_nxt       = GEN_BITS'(in_gen);
          idx_nxt       = SLOT_IDX_W'(in_slot);
          mem_req.rd_en = 1'b1;
          state_nxt     = (cmd_t'(in_cmd) == CMD_ALLOC) ? S_FIND : S_EXEC;
        end
      end
      S_FIND: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        idx_nxt       = fnd_slot;
        full_nxt      = !fnd_found;
        mem_req.rd_en = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || out_tready) begin
          if (cmd_r == CMD_ALLOC) begin
            if (full_r) begin
              st    = ST_FULL;
              oslot = '0;
            end else begin
              st             = ST_OK;
              oslot          = SLOT_W'(idx_r);
              ogen           = cur_gen;
              occ_nxt[idx_r]  = 1'b1;
              pend_nxt[idx_r] = 1'b0;
            end
          end else if (in_range) begin
            ogen = cur_gen;
            case (cmd_r)
              CMD_FORCE: begin
                if (occ_r[idx_r]) begin
                  st = ST_OCCUPIED;
                end else begin
                  st               = ST_OK;
                  ogen             = gen_r;
                  occ_nxt[idx_r]   = 1'b1;
                  pend_nxt[idx_r]  = 1'b0;
                  gvld_nxt[idx_r]  = 1'b1;
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_data  = gen_r;
                end
              end
              CMD_EXISTS: begin
                st  = ST_OK;
                ans = match;
              end
              CMD_ALIVE: begin
                st  = ST_OK;
                ans = match && !pend_r[idx_r];
              end
              CMD_REQ_DEL: begin
                if (match) begin
                  st              = ST_OK;
                  pend_nxt[idx_r] = 1'b1;
                end
              end
              CMD_DELETE: begin
                if (match) begin
                  st              = ST_OK;
                  ogen            = gen_inc;
                  occ_nxt[idx_r]  = 1'b0;
                  gvld_nxt[idx_r] = 1'b1;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = gen_inc;
                end
              end
              default: begin
                // undefined command: not found, no generation
                ogen = '0;
              end
            endcase
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = TDATA_W'({GEN_W'(ogen), oslot, ans, st});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mem_req.rd_en) begin
      gvld_q_nxt = gvld_r[mem_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pend_r      <= '0;
      gvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      gvld_r      <= gvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    gen_r      <= gen_nxt;
    idx_r      <= idx_nxt;
    full_r     <= full_nxt;
    gvld_q_r   <= gvld_q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* src/gha_checker.sv */
// ============================================================================
// gha_checker - port-level checks for the handle allocator
// Watches the request and result streams of the top level.
// ============================================================================
`default_nettype none

module gha_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [gha_pkg::TDATA_W-1:0] out_tdata
);

  import gha_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A full table grants no slot and no generation
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_FULL) |-> (out_tdata[24:2] == '0))
    else $error("table full result carries slot or generation");

  // A set answer only comes with an ok status
  a_answer_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> (out_tdata[1:0] == ST_OK))
    else $error("answer set with non-ok status");

  // Busy in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

  // Reset clears the result stream
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the generational handle allocator
// Drives request streams (directed corner cases, a full table, a long output
// hold-off and a random mix of mostly well-formed handle traffic), predicts
// every reply from a local copy of the slot table and checks each reply field
// by field in arrival order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES = 7;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          MIX_COUNT    = 750;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          PAD_W        = TDATA_W - GEN_W - SLOT_W - 1 - STATUS_W;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // reply word, laid out as out_tdata
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] slot;
    logic              answer;
    status_t           status;
  } reply_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;

  // local copy of the slot table
  logic                slot_used [SLOTS];
  logic [GEN_BITS-1:0] slot_gen  [SLOTS];
  logic                del_mark  [SLOTS];

  reply_t      reply_fifo[$];
  int          mismatch_count = 0;
  int unsigned reply_index    = 0;
  int unsigned cycle_count    = 0;
  logic        idle_on        = 1'b1;
  int          hold_reqs      = 0;
  int          hold_served    = 0;
  int          hold_left      = 0;

  generational_handle_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the table copy and return the reply it must give.
  function automatic reply_t allocator_reply(logic [CMD_W-1:0] cmd,
                                             logic [SLOT_W-1:0] slot,
                                             logic [GEN_W-1:0] gen);
    reply_t r;
    logic   hit;
    r        = '0;
    r.status = ST_NOT_FOUND;
    r.slot   = slot;
    if (cmd == CMD_ALLOC) begin
      r.status = ST_FULL;
      r.slot   = '0;
      for (int s = 1; s < SLOTS; s++) begin
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          del_mark[s]  = 1'b0;
          r.status     = ST_OK;
          r.slot       = SLOT_W'(s);
          r.gen        = slot_gen[s];
          break;
        end
      end
    end else if (cmd <= CMD_DELETE && slot < SLOTS) begin
      hit = slot_used[slot] && slot_gen[slot] == gen;
      case (cmd)
        CMD_FORCE: begin
          if (slot_used[slot]) begin
            r.status = ST_OCCUPIED;
          end else begin
            slot_used[slot] = 1'b1;
            slot_gen[slot]  = gen;
            del_mark[slot]  = 1'b0;
            r.status        = ST_OK;
          end
        end
        CMD_EXISTS: begin
          r.status = ST_OK;
          r.answer = hit;
        end
        CMD_ALIVE: begin
          r.status = ST_OK;
          r.answer = hit && !del_mark[slot];
        end
        CMD_REQ_DEL: begin
          if (hit) begin
            del_mark[slot] = 1'b1;
            r.status       = ST_OK;
          end
        end
        default: begin
          // delete leaves the mark for the next allocation to clear
          if (hit) begin
            slot_used[slot] = 1'b0;
            slot_gen[slot]  = slot_gen[slot] + 1'b1;
            r.status        = ST_OK;
          end
        end
      endcase
      r.gen = slot_gen[slot];
    end
    return r;
  endfunction

  // Offer one request, wait for its handshake, then queue its reply.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [SLOT_W-1:0] slot,
                              input logic [GEN_W-1:0] gen);
    if (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, gen, slot, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    reply_fifo.push_back(allocator_reply(cmd, slot, gen));
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on) begin
      out_tready <= ($urandom_range(99) >= 30);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = reply_t'(out_tdata);
      if (reply_fifo.size() == 0) begin
        if (mismatch_count < 10)
          $display("reply %0d arrived with none outstanding: %h", reply_index, out_tdata);
        mismatch_count++;
      end else begin
        want = reply_fifo.pop_front();
        if (got.status !== want.status || got.answer !== want.answer ||
            got.slot !== want.slot || got.gen !== want.gen || got.pad !== want.pad) begin
          if (mismatch_count < 10)
            $display({"reply %0d: want st=%0d ans=%0d slot=%0d gen=%h pad=%h, ",
                      "got st=%0d ans=%0d slot=%0d gen=%h pad=%h"},
                     reply_index, want.status, want.answer, want.slot, want.gen,
                     want.pad, got.status, got.answer, got.slot, got.gen, got.pad);
          mismatch_count++;
        end
      end
      reply_index++;
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_directed_cases();
    send_request(CMD_EXISTS,  6'd0,  16'h0000);  // empty table
    send_request(CMD_ALLOC,   6'd17, 16'hFFFF);  // lowest free is slot 1
    send_request(CMD_EXISTS,  6'd1,  16'h0000);
    send_request(CMD_ALIVE,   6'd1,  16'h0000);
    send_request(CMD_EXISTS,  6'd1,  16'hFFFF);  // stale generation
    send_request(CMD_REQ_DEL, 6'd1,  16'h0000);
    send_request(CMD_ALIVE,   6'd1,  16'h0000);  // marked: exists but not alive
    send_request(CMD_EXISTS,  6'd1,  16'h0000);
    send_request(CMD_REQ_DEL, 6'd2,  16'h0000);  // missing handle
    send_request(CMD_DELETE,  6'd1,  16'h0000);
    send_request(CMD_DELETE,  6'd1,  16'h0000);  // already freed
    send_request(CMD_FORCE,   6'd0,  16'hFFFF);  // reserved slot taken by force
    send_request(CMD_FORCE,   6'd0,  16'h1234);  // occupied
    send_request(CMD_DELETE,  6'd0,  16'hFFFF);  // generation wraps to zero
    send_request(CMD_EXISTS,  6'd0,  16'h0000);
    send_request(CMD_FORCE,   6'd63, 16'h8000);
    send_request(CMD_ALIVE,   6'd63, 16'h8000);
    send_request(CMD_SPARE_A, 6'd63, 16'hFFFF);
    send_request(CMD_SPARE_B, 6'd42, 16'h5A5A);
    send_request(CMD_ALLOC,   6'd0,  16'h0000);  // slot 1 again, mark cleared
    send_request(CMD_ALIVE,   6'd1,  16'h0001);
    send_request(CMD_DELETE,  6'd63, 16'h7FFF);  // wrong generation
  endtask

  task automatic test_table_full();
    int free_slots;
    free_slots = 0;
    for (int s = 1; s < SLOTS; s++) if (!slot_used[s]) free_slots++;
    repeat (free_slots + 2) send_request(CMD_ALLOC, 6'($urandom_range(63)), 16'h0000);
    send_request(CMD_FORCE, 6'd20, 16'hABCD);
    // free every even slot from 2 up, then refill the lowest one
    for (int s = 2; s < SLOTS; s += 2) send_request(CMD_DELETE, 6'(s), slot_gen[s]);
    send_request(CMD_ALLOC, 6'd0, 16'h0000);
  endtask

  task automatic test_receiver_hold();
    logic idle_saved;
    idle_saved = idle_on;
    idle_on    = 1'b0;
    hold_reqs  = hold_reqs + 1;
    // keep offering through the hold-off so the input side backs up
    repeat (24) send_request(CMD_EXISTS, 6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)));
    idle_on = idle_saved;
  endtask

  task automatic test_random_mix(input int count);
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    int                pick;
    int                base;
    int                live;
    for (int i = 0; i < count; i++) begin
      // first stretch runs without idling on either side
      idle_on = (i >= 250);
      pick = $urandom_range(99);
      if (pick < 22)      cmd = CMD_ALLOC;
      else if (pick < 30) cmd = CMD_FORCE;
      else if (pick < 48) cmd = CMD_EXISTS;
      else if (pick < 62) cmd = CMD_ALIVE;
      else if (pick < 76) cmd = CMD_REQ_DEL;
      else if (pick < 96) cmd = CMD_DELETE;
      else                cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      // find an occupied slot from a random start
      base = $urandom_range(SLOTS - 1);
      live = -1;
      for (int k = 0; k < SLOTS; k++) begin
        if (live < 0 && slot_used[(base + k) % SLOTS]) live = (base + k) % SLOTS;
      end
      slot = 6'($urandom_range(63));
      gen  = 16'($urandom_range(16'hFFFF));
      pick = $urandom_range(99);
      if (cmd != CMD_ALLOC && cmd != CMD_FORCE && live >= 0 && pick < 85) begin
        slot = 6'(live);
        gen  = slot_gen[live];
        // spoil one bit of the generation now and then
        if (pick >= 70) gen[$urandom_range(GEN_W - 1)] ^= 1'b1;
      end
      send_request(cmd, slot, gen);
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_gen[s]  = '0;
      del_mark[s]  = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_table_full();
    test_receiver_hold();
    test_random_mix(MIX_COUNT);

    in_tvalid <= 1'b0;
    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
